// ----- rtl/simad_pkg.sv -----
// Shared widths, register indexes and control interface types for the shifted image SAD block.
package simad_pkg;

  localparam int MAX_SIDE   = 4096;
  localparam int LANES      = 16;
  localparam int SIDE_W     = 13;
  localparam int BYTE_W     = 8;
  localparam int TAKE_W     = $clog2(LANES) + 1;
  localparam int LANE_SAD_W = BYTE_W + $clog2(LANES);
  localparam int SUM_W      = 32;
  localparam int CNT_W      = 25;
  localparam int MEAN_W     = 16;
  localparam int FRAC_W     = 8;
  localparam int DIVD_W     = SUM_W + FRAC_W;
  localparam int DIV_STEPS  = DIVD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int IN_W       = 4 * 64;
  localparam int OUT_USED_W = SUM_W + CNT_W + MEAN_W;
  localparam int OUT_W      = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_W - OUT_USED_W;
  localparam int CFG_IDX_W  = 3;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_B = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_X  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SHIFT_Y  = 3'd5;

  typedef struct packed {
    logic accept;
    logic restart;
    logic load_empty;
    logic div_start;
    logic div_step;
    logic load_result;
  } cmd_t;

  typedef struct packed {
    logic cfg_pending;
    logic frame_end;
    logic empty;
    logic out_busy;
    logic div_last;
  } sts_t;

endpackage

// ----- rtl/simad_ctrl.sv -----
// Frame sequencer: input handshake, end-of-frame handling and divider control.
module simad_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  simad_pkg::sts_t    sts,
  output simad_pkg::cmd_t    cmd
);
  import simad_pkg::*;

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_LOAD = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_RUN) && !sts.cfg_pending && !(sts.frame_end && sts.out_busy);

  always_comb begin
    cmd             = '0;
    cmd.accept      = in_tvalid && in_tready;
    cmd.restart     = sts.cfg_pending;
    cmd.load_empty  = cmd.accept && sts.empty;
    cmd.div_start   = (state_r == ST_SUM);
    cmd.div_step    = (state_r == ST_DIV);
    cmd.load_result = (state_r == ST_LOAD);
  end

  always_comb begin
    state_nxt = state_r;
    if (sts.cfg_pending) begin
      state_nxt = ST_RUN;
    end else begin
      case (state_r)
        ST_RUN: begin
          if (cmd.accept && sts.frame_end && !sts.empty) begin
            state_nxt = ST_SUM;
          end
        end
        ST_SUM: begin
          state_nxt = ST_DIV;
        end
        ST_DIV: begin
          if (sts.div_last) begin
            state_nxt = ST_LOAD;
          end
        end
        ST_LOAD: begin
          state_nxt = ST_RUN;
        end
        default: begin
          state_nxt = ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> !sts.out_busy)
    else $error("result loaded while output still pending");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && !sts.div_last && !sts.cfg_pending |=> state_r == ST_DIV)
    else $error("divider left before last step");
`endif

endmodule

// ----- rtl/simad_dp.sv -----
// Datapath: config registers, overlap setup, lane SAD, accumulator, divider, output register.
module simad_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  simad_pkg::cmd_t               cmd,
  output simad_pkg::sts_t               sts,
  input  logic [simad_pkg::IN_W-1:0]    in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [simad_pkg::OUT_W-1:0]   out_tdata,
  output logic                          out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [simad_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [simad_pkg::SIDE_W-1:0]  cfg_data
);
  import simad_pkg::*;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
    return (v > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : v;
  endfunction

  function automatic logic [SIDE_W-1:0] overlap_extent(input logic [SIDE_W-1:0] sa,
                                                       input logic [SIDE_W-1:0] sb,
                                                       input logic [SIDE_W-1:0] sh);
    logic signed [SIDE_W+1:0] a, b, s, p, q, e;
    a = signed'({2'b00, clamp_side(sa)});
    b = signed'({2'b00, clamp_side(sb)});
    s = signed'({{2{sh[SIDE_W-1]}}, sh});
    p = a - ((s > 0) ? s : '0);
    q = b + ((s < 0) ? s : '0);
    e = (p < q) ? p : q;
    return (e > 0) ? e[SIDE_W-1:0] : '0;
  endfunction

  logic [SIDE_W-1:0] width_a_r, height_a_r, width_b_r, height_b_r, shift_x_r, shift_y_r;
  logic              cfg_pend_r;
  logic [SIDE_W-1:0] cols_r, rows_r, col_pos_r, row_pos_r;
  logic [CNT_W-1:0]  count_r;
  logic [2*SIDE_W-1:0] prod;

  logic [SIDE_W-1:0] remain;
  logic              chunk_last, row_last, empty;
  logic [TAKE_W-1:0] take;

  logic [BYTE_W-1:0]       diff [LANES];
  logic [BYTE_W:0]         lvl1 [8];
  logic [BYTE_W+1:0]       lvl2 [4];
  logic [BYTE_W+2:0]       lvl3 [2];
  logic [LANE_SAD_W-1:0]   lane_sum;

  logic                  s1_valid_r;
  logic [LANE_SAD_W-1:0] sad_r;
  logic [SUM_W-1:0]      running_sum_r, sum_fin, total_r;

  logic [DIVD_W-1:0]    div_work_r;
  logic [CNT_W-1:0]     div_rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [CNT_W:0]       trial;
  logic                 ge;
  logic [CNT_W:0]       trial_sub;

  logic                 out_valid_r, out_user_r;
  logic [OUT_W-1:0]     out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_a_r  <= SIDE_W'(1);
      height_a_r <= SIDE_W'(1);
      width_b_r  <= SIDE_W'(1);
      height_b_r <= SIDE_W'(1);
      shift_x_r  <= '0;
      shift_y_r  <= '0;
      cfg_pend_r <= 1'b0;
    end else begin
      cfg_pend_r <= 1'b0;
      if (cfg_valid) begin
        case (cfg_index)
          REG_WIDTH_A: begin
            width_a_r  <= cfg_data;
            cfg_pend_r <= 1'b1;
          end
          REG_HEIGHT_A: begin
            height_a_r <= cfg_data;
            cfg_pend_r <= 1'b1;
          end
          REG_WIDTH_B: begin
            width_b_r  <= cfg_data;
            cfg_pend_r <= 1'b1;
          end
          REG_HEIGHT_B: begin
            height_b_r <= cfg_data;
            cfg_pend_r <= 1'b1;
          end
          REG_SHIFT_X: begin
            shift_x_r  <= cfg_data;
            cfg_pend_r <= 1'b1;
          end
          REG_SHIFT_Y: begin
            shift_y_r  <= cfg_data;
            cfg_pend_r <= 1'b1;
          end
          default: begin
            cfg_pend_r <= 1'b0;
          end
        endcase
      end
    end
  end

  assign prod = cols_r * rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r  <= SIDE_W'(1);
      rows_r  <= SIDE_W'(1);
      count_r <= CNT_W'(1);
    end else begin
      count_r <= prod[CNT_W-1:0];
      if (cmd.restart) begin
        cols_r <= overlap_extent(width_a_r, width_b_r, shift_x_r);
        rows_r <= overlap_extent(height_a_r, height_b_r, shift_y_r);
      end
    end
  end

  assign remain     = cols_r - col_pos_r;
  assign chunk_last = (remain <= SIDE_W'(LANES));
  assign row_last   = (row_pos_r == (rows_r - SIDE_W'(1)));
  assign empty      = (cols_r == '0) || (rows_r == '0);
  assign take       = chunk_last ? remain[TAKE_W-1:0] : TAKE_W'(LANES);

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      logic [BYTE_W-1:0] fa, fb;
      fa = in_tdata[BYTE_W*i +: BYTE_W];
      fb = in_tdata[IN_W/2 + BYTE_W*i +: BYTE_W];
      if (TAKE_W'(i) < take) begin
        diff[i] = (fa > fb) ? (fa - fb) : (fb - fa);
      end else begin
        diff[i] = '0;
      end
    end
    for (int i = 0; i < 8; i++) begin
      lvl1[i] = {1'b0, diff[2*i]} + {1'b0, diff[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      lvl2[i] = {1'b0, lvl1[2*i]} + {1'b0, lvl1[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      lvl3[i] = {1'b0, lvl2[2*i]} + {1'b0, lvl2[2*i+1]};
    end
    lane_sum = {1'b0, lvl3[0]} + {1'b0, lvl3[1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (cmd.restart) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
    end else if (cmd.accept && !empty) begin
      if (chunk_last) begin
        col_pos_r <= '0;
        row_pos_r <= row_last ? '0 : (row_pos_r + SIDE_W'(1));
      end else begin
        col_pos_r <= col_pos_r + SIDE_W'(LANES);
      end
    end
  end

  assign sum_fin = running_sum_r + SUM_W'(sad_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      running_sum_r <= '0;
    end else begin
      s1_valid_r <= cmd.accept && !empty && !cmd.restart;
      if (cmd.restart) begin
        running_sum_r <= '0;
      end else if (s1_valid_r) begin
        running_sum_r <= cmd.div_start ? '0 : sum_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sad_r <= lane_sum;
    end
    if (cmd.div_start) begin
      total_r <= sum_fin;
    end
  end

  assign trial     = {div_rem_r, div_work_r[DIVD_W-1]};
  assign trial_sub = trial - {1'b0, count_r};
  assign ge        = (trial >= {1'b0, count_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.div_start) begin
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_work_r <= {sum_fin, FRAC_W'(0)};
      div_rem_r  <= '0;
    end else if (cmd.div_step) begin
      div_work_r <= {div_work_r[DIVD_W-2:0], ge};
      div_rem_r  <= ge ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_empty || cmd.load_result) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_empty) begin
      out_data_r <= '0;
      out_user_r <= 1'b1;
    end else if (cmd.load_result) begin
      out_data_r <= {OUT_PAD_W'(0), div_work_r[MEAN_W-1:0], count_r, total_r};
      out_user_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    sts             = '0;
    sts.cfg_pending = cfg_pend_r;
    sts.frame_end   = empty || (chunk_last && row_last);
    sts.empty       = empty;
    sts.out_busy    = out_valid_r;
    sts.div_last    = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  end

`ifndef SYNTHESIS
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_empty || cmd.load_result))
    else $error("output valid raised without a load");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> div_rem_r < count_r)
    else $error("divider remainder not below divisor");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> col_pos_r < cols_r)
    else $error("column position beyond overlap");

  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_result |-> div_work_r[DIVD_W-1:MEAN_W] == '0)
    else $error("mean quotient exceeds output width");
`endif

endmodule

// ----- rtl/shifted_image_mean_abs_difference_top.sv -----
// Top level: shifted image sum of absolute differences with mean.
// Throughput: one 16-pixel chunk per cycle within a frame, while no config write
// is pending. The last chunk of a frame waits while the output is busy and then
// runs the sum state, a 40-step bit-serial restoring divider and the load state.
// With an empty overlap each item gives its result in the next cycle.
// A write to a config register blocks input while the overlap is recomputed.
// Reset is synchronous, active low; registers return to a 1x1 image pair, no shift.
module shifted_image_mean_abs_difference_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // first_low_bytes, first_high_bytes, second_low_bytes, second_high_bytes
  input  logic [simad_pkg::IN_W-1:0]        in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // abs_diff_total, pixel_total, mean_difference, zero fill
  output logic [simad_pkg::OUT_W-1:0]       out_tdata,
  // overlap_empty
  output logic                              out_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [simad_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [simad_pkg::SIDE_W-1:0]      cfg_data
);
  import simad_pkg::*;

  cmd_t cmd;
  sts_t sts;

  simad_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  simad_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

endmodule

// ----- verif/shifted_image_mean_abs_difference_top_tb.sv -----
// Testbench for the shifted image SAD block: directed and random frames checked against a model.
module shifted_image_mean_abs_difference_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import simad_pkg::*;

  localparam int NUM_REGS       = int'(REG_SHIFT_Y) + 1;
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ITEM_TARGET    = 1400;
  localparam int HALF_W         = IN_W / 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CNT_W-1:0]  count;
    logic [MEAN_W-1:0] mean;
    logic              empty;
  } sad_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIDE_W-1:0]    cfg_data = '0;

  logic [SIDE_W-1:0] reg_mirror [NUM_REGS];
  int                ov_cols, ov_rows, col_pos, row_pos;
  logic [SUM_W-1:0]  acc_sum;
  sad_result_t       expected_sads[$];

  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit no_gaps = 1'b0;

  shifted_image_mean_abs_difference_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_side(logic [SIDE_W-1:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  function automatic int overlap_extent(logic [SIDE_W-1:0] size_a, logic [SIDE_W-1:0] size_b,
                                        logic [SIDE_W-1:0] shift);
    int a, b, s, p, q, e;
    a = clamp_side(size_a);
    b = clamp_side(size_b);
    s = $signed(shift);
    p = a - ((s > 0) ? s : 0);
    q = b + ((s < 0) ? s : 0);
    e = (p < q) ? p : q;
    return (e > 0) ? e : 0;
  endfunction

  function automatic void restart_frame();
    ov_cols = overlap_extent(reg_mirror[REG_WIDTH_A], reg_mirror[REG_WIDTH_B],
                             reg_mirror[REG_SHIFT_X]);
    ov_rows = overlap_extent(reg_mirror[REG_HEIGHT_A], reg_mirror[REG_HEIGHT_B],
                             reg_mirror[REG_SHIFT_Y]);
    col_pos = 0;
    row_pos = 0;
    acc_sum = '0;
  endfunction

  function automatic void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
    if (idx > REG_SHIFT_Y) return;
    reg_mirror[idx] = val;
    restart_frame();
  endfunction

  function automatic int frame_chunks();
    if (ov_cols == 0 || ov_rows == 0) return 0;
    return ((ov_cols + LANES - 1) / LANES) * ov_rows;
  endfunction

  function automatic void predict_chunk(logic [IN_W-1:0] d);
    int take, i, cnt;
    logic [BYTE_W-1:0] pa, pb;
    logic [63:0] quotient;
    sad_result_t r;
    r = '0;
    if (ov_cols == 0 || ov_rows == 0) begin
      r.empty = 1'b1;
      expected_sads.push_back(r);
      return;
    end
    take = (ov_cols - col_pos >= LANES) ? LANES : ov_cols - col_pos;
    for (i = 0; i < take; i++) begin
      pa = d[BYTE_W*i +: BYTE_W];
      pb = d[HALF_W + BYTE_W*i +: BYTE_W];
      acc_sum += (pa > pb) ? pa - pb : pb - pa;
    end
    col_pos += take;
    if (col_pos < ov_cols) return;
    col_pos = 0;
    row_pos++;
    if (row_pos < ov_rows) return;
    cnt = ov_cols * ov_rows;
    quotient = (64'(acc_sum) << FRAC_W) / 64'(cnt);
    r.sum = acc_sum;
    r.count = CNT_W'(cnt);
    r.mean = quotient[MEAN_W-1:0];
    expected_sads.push_back(r);
    row_pos = 0;
    acc_sum = '0;
  endfunction

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [IN_W-1:0] make_chunk(logic [HALF_W-1:0] first,
                                                 logic [HALF_W-1:0] second);
    return {second, first};
  endfunction

  function automatic logic [IN_W-1:0] random_chunk();
    logic [IN_W-1:0] d;
    for (int k = 0; k < IN_W / 32; k++) d[32*k +: 32] = $urandom;
    return d;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("tb: mismatch in %s: got %0d, want %0d", what, got, want);
    errors++;
  endtask

  task automatic send_chunk(logic [IN_W-1:0] d);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
    predict_chunk(d);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SIDE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_cfg(idx, val);
    @(negedge clk);
  endtask

  // drain results and let the divider finish before reconfiguring; a partial frame is dropped
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_sads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_geometry(int wa, int ha, int wb, int hb, int sx, int sy);
    settle();
    write_reg(REG_WIDTH_A, SIDE_W'(wa));
    write_reg(REG_HEIGHT_A, SIDE_W'(ha));
    write_reg(REG_WIDTH_B, SIDE_W'(wb));
    write_reg(REG_HEIGHT_B, SIDE_W'(hb));
    write_reg(REG_SHIFT_X, SIDE_W'(sx));
    write_reg(REG_SHIFT_Y, SIDE_W'(sy));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_frames(int n);
    repeat (n * frame_chunks()) send_chunk(random_chunk());
  endtask

  task automatic test_reset_state();
    logic [IN_W-1:0] noise_a, noise_b;
    noise_a = random_chunk();
    noise_b = random_chunk();
    send_chunk(make_chunk({16{8'hFF}}, '0));
    send_chunk(make_chunk('0, {16{8'hFF}}));
    send_chunk(make_chunk({noise_a[HALF_W-1:8], 8'h37},
                          {noise_b[HALF_W-1:8], 8'h37}));
  endtask

  task automatic test_row_tails();
    set_geometry(16, 1, 16, 1, 0, 0);
    send_chunk(make_chunk({16{8'hFF}}, '0));
    set_geometry(17, 1, 17, 1, 0, 0);
    send_frames(1);
    set_geometry(15, 2, 15, 2, 0, 0);
    send_frames(1);
  endtask

  task automatic test_shift_extremes();
    set_geometry(MAX_SIDE, 1, MAX_SIDE, 1, MAX_SIDE - 1, 0);
    send_frames(1);
    set_geometry(MAX_SIDE, MAX_SIDE, MAX_SIDE, MAX_SIDE, 1 - MAX_SIDE, 1 - MAX_SIDE);
    send_frames(1);
    set_geometry(8191, 2, 8191, 2, MAX_SIDE - 6, 0);
    send_frames(1);
    set_geometry(3, 1, 40, 2, -20, -1);
    send_frames(1);
    set_geometry(40, 3, 3, 3, 5, 1);
    send_frames(1);
  endtask

  task automatic test_empty_overlap();
    set_geometry(5, 5, 0, 5, 0, 0);
    send_chunk(random_chunk());
    send_chunk(random_chunk());
    set_geometry(1, 1, 1, 1, -MAX_SIDE, 0);
    send_chunk(random_chunk());
    set_geometry(4, 4, 4, 4, 0, 4);
    send_chunk(random_chunk());
  endtask

  task automatic test_spare_index();
    set_geometry(20, 2, 20, 2, 0, 0);
    send_chunk(random_chunk());
    send_chunk(random_chunk());
    settle();
    write_reg(REG_SPARE_LO, SIDE_W'($urandom));
    write_reg(REG_SPARE_HI, SIDE_W'($urandom));
    cfg_valid <= 1'b0;
    send_chunk(random_chunk());
    send_chunk(random_chunk());
    send_chunk(random_chunk());
    settle();
    write_reg(REG_WIDTH_A, SIDE_W'(20));
    cfg_valid <= 1'b0;
    send_frames(1);
  endtask

  task automatic test_random_frames();
    int base, pick, fc, n;
    int wa, ha, wb, hb, sx, sy;
    base = items_sent;
    while (items_sent - base < ITEM_TARGET) begin
      pick = $urandom_range(0, 29);
      if (pick == 0) begin
        wa = $urandom_range(4000, 8191);
        wb = $urandom_range(4000, 8191);
        ha = $urandom_range(1, 2);
        hb = $urandom_range(1, 2);
        sx = int'($urandom_range(0, 200)) - 100;
        sy = 0;
      end else if (pick < 4) begin
        wa = $urandom_range(0, 8191);
        wb = $urandom_range(0, 8191);
        ha = $urandom_range(0, 8191);
        hb = $urandom_range(0, 8191);
        sx = $urandom_range(0, 8191);
        sy = $urandom_range(0, 8191);
      end else begin
        wa = $urandom_range(1, 70);
        wb = $urandom_range(1, 70);
        ha = $urandom_range(1, 5);
        hb = $urandom_range(1, 5);
        sx = int'($urandom_range(0, 24)) - 12;
        sy = int'($urandom_range(0, 8)) - 4;
      end
      no_gaps = ($urandom_range(0, 3) == 0);
      set_geometry(wa, ha, wb, hb, sx, sy);
      fc = frame_chunks();
      if (fc == 0) n = $urandom_range(1, 6);
      else if (fc > 600) n = $urandom_range(1, 40);
      else n = fc * $urandom_range(1, 3) + (($urandom_range(0, 3) == 0) ?
                                              $urandom_range(0, fc - 1) : 0);
      if (n > ITEM_TARGET - (items_sent - base)) n = ITEM_TARGET - (items_sent - base);
      repeat (n) send_chunk(random_chunk());
    end
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = draw_gap();
    end
  end

  always @(posedge clk) begin
    sad_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_sads.size() == 0) begin
        report_mismatch("unexpected result sum", out_tdata[SUM_W-1:0], 0);
      end else begin
        want = expected_sads.pop_front();
        if (out_tdata[SUM_W-1:0] !== want.sum)
          report_mismatch("abs_diff_total", out_tdata[SUM_W-1:0], want.sum);
        if (out_tdata[SUM_W +: CNT_W] !== want.count)
          report_mismatch("pixel_total", out_tdata[SUM_W +: CNT_W], want.count);
        if (out_tdata[SUM_W+CNT_W +: MEAN_W] !== want.mean)
          report_mismatch("mean_difference", out_tdata[SUM_W+CNT_W +: MEAN_W], want.mean);
        if (out_tuser !== want.empty)
          report_mismatch("overlap_empty", out_tuser, want.empty);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    reg_mirror[REG_WIDTH_A] = 1;
    reg_mirror[REG_HEIGHT_A] = 1;
    reg_mirror[REG_WIDTH_B] = 1;
    reg_mirror[REG_HEIGHT_B] = 1;
    reg_mirror[REG_SHIFT_X] = 0;
    reg_mirror[REG_SHIFT_Y] = 0;
    restart_frame();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_row_tails();
    test_shift_extremes();
    test_empty_overlap();
    test_spare_index();
    test_random_frames();
    settle();
    if (errors == 0 && expected_sads.size() == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/simad_pkg.sv
rtl/simad_ctrl.sv
rtl/simad_dp.sv
rtl/shifted_image_mean_abs_difference_top.sv
verif/shifted_image_mean_abs_difference_top_tb.sv
